// File: src/tsre_pkg.sv
`timescale 1ns / 1ps

package tsre_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 14;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MIN_VALID_TEMP      = 3'd0,
      CSR_MAX_VALID_TEMP      = 3'd1,
      CSR_SPIKE_THRESHOLD     = 3'd2,
      CSR_CORRECTION_OFFSET   = 3'd3,
      CSR_BAD_READ_LIMIT      = 3'd4,
      CSR_SPIKE_CONFIRM_COUNT = 3'd5,
      CSR_VALID_AFTER_COUNT   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_UPDATED = 2'd0,
      STATUS_BAD     = 2'd1,
      STATUS_SPIKE   = 2'd2
   } status_type;

   localparam logic signed [13:0] MIN_VALID_TEMP_RESET      = -14'sd2560;
   localparam logic signed [13:0] MAX_VALID_TEMP_RESET      = 14'sd5760;
   localparam logic [10:0]        SPIKE_THRESHOLD_RESET     = 11'd256;
   localparam logic signed [10:0] CORRECTION_OFFSET_RESET   = 11'sd0;
   localparam logic [3:0]         BAD_READ_LIMIT_RESET      = 4'd5;
   localparam logic [3:0]         SPIKE_CONFIRM_COUNT_RESET = 4'd2;
   localparam logic [7:0]         VALID_AFTER_COUNT_RESET   = 8'd3;

   // Divide by five: floor(u / 5) == (u * DIV5_RECIP) >> DIV5_SHIFT for u < 2**18.
   localparam logic [16:0] DIV5_RECIP = 17'd52429;
   localparam int          DIV5_SHIFT = 18;
   // Bias that keeps the dividend non-negative: 5 * 8192.
   localparam logic [16:0] DIV5_BIAS  = 17'd40960;
   localparam logic [15:0] DIV5_UNBIAS = 16'd8192;

   typedef struct packed {
      logic signed [13:0] min_valid_temp;
      logic signed [13:0] max_valid_temp;
      logic [10:0]        spike_threshold;
      logic signed [10:0] correction_offset;
      logic [3:0]         bad_read_limit;
      logic [3:0]         spike_confirm_count;
      logic [7:0]         valid_after_count;
   } cfg_type;

   typedef struct packed {
      logic signed [13:0] filtered_temp;
      logic               have_filtered;
      logic [3:0]         spike_streak;
      logic [3:0]         bad_count;
      logic [7:0]         good_streak;
      logic               valid_flag;
   } state_type;

   typedef struct packed {
      logic signed [15:0] shown_temp;
      status_type         status;
      logic               reinit_request;
      logic               live;
      logic               local_valid;
   } result_type;

endpackage

// File: src/tsre_req_if.sv
`timescale 1ns / 1ps

interface tsre_req_if;
   logic               valid;
   logic               ready;
   logic               read_ok;
   logic signed [15:0] sample;

   modport source (output valid, output read_ok, output sample, input ready);
   modport sink   (input valid, input read_ok, input sample, output ready);
endinterface

// File: src/tsre_rsp_if.sv
`timescale 1ns / 1ps

interface tsre_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] shown_temp;
   logic [1:0]         status;
   logic               reinit_request;
   logic               live;
   logic               local_valid;

   modport source (output valid, output shown_temp, output status, output reinit_request,
                   output live, output local_valid, input ready);
   modport sink   (input valid, input shown_temp, input status, input reinit_request,
                   input live, input local_valid, output ready);
endinterface

// File: src/tsre_csr.sv
`timescale 1ns / 1ps

module tsre_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [tsre_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tsre_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output tsre_pkg::cfg_type                      cfg
);
   import tsre_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_valid_temp      <= MIN_VALID_TEMP_RESET;
         cfg_ff.max_valid_temp      <= MAX_VALID_TEMP_RESET;
         cfg_ff.spike_threshold     <= SPIKE_THRESHOLD_RESET;
         cfg_ff.correction_offset   <= CORRECTION_OFFSET_RESET;
         cfg_ff.bad_read_limit      <= BAD_READ_LIMIT_RESET;
         cfg_ff.spike_confirm_count <= SPIKE_CONFIRM_COUNT_RESET;
         cfg_ff.valid_after_count   <= VALID_AFTER_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_VALID_TEMP:      cfg_ff.min_valid_temp      <= $signed(csr_wdata[13:0]);
            CSR_MAX_VALID_TEMP:      cfg_ff.max_valid_temp      <= $signed(csr_wdata[13:0]);
            CSR_SPIKE_THRESHOLD:     cfg_ff.spike_threshold     <= csr_wdata[10:0];
            CSR_CORRECTION_OFFSET:   cfg_ff.correction_offset   <= $signed(csr_wdata[10:0]);
            CSR_BAD_READ_LIMIT:      cfg_ff.bad_read_limit      <= csr_wdata[3:0];
            CSR_SPIKE_CONFIRM_COUNT: cfg_ff.spike_confirm_count <= csr_wdata[3:0];
            CSR_VALID_AFTER_COUNT:   cfg_ff.valid_after_count   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/tsre_step.sv
`timescale 1ns / 1ps

module tsre_step (
   input  tsre_pkg::cfg_type     cfg,
   input  tsre_pkg::state_type   state,
   input  logic                  read_ok,
   input  logic signed [15:0]    sample,
   output tsre_pkg::state_type   state_next,
   output tsre_pkg::result_type  result
);
   import tsre_pkg::*;

   logic signed [15:0] min_ext;
   logic signed [15:0] max_ext;
   logic               bad;
   logic signed [13:0] s14;
   logic signed [14:0] diff;
   logic [14:0]        abs_diff;
   logic               spike;
   logic [3:0]         streak_sat;
   logic [4:0]         bad_inc;
   logic [7:0]         good_sat;
   logic signed [16:0] acc;
   logic [16:0]        acc_bias;
   logic [33:0]        prod;
   logic [15:0]        quo;
   logic [15:0]        avg_full;
   logic signed [13:0] avg;
   logic               update;
   logic signed [14:0] shown_sum;
   state_type          nxt;
   status_type         status;
   logic               reinit;

   assign min_ext = $signed({{2{cfg.min_valid_temp[13]}}, cfg.min_valid_temp});
   assign max_ext = $signed({{2{cfg.max_valid_temp[13]}}, cfg.max_valid_temp});
   assign bad     = !read_ok || (sample < min_ext) || (sample > max_ext);

   // A good sample always lies within the 14-bit configuration range.
   assign s14      = $signed(sample[13:0]);
   assign diff     = $signed({s14[13], s14}) - $signed({state.filtered_temp[13],
                                                        state.filtered_temp});
   assign abs_diff = diff[14] ? 15'(-diff) : 15'(diff);
   assign spike    = abs_diff > {4'd0, cfg.spike_threshold};

   assign streak_sat = (state.spike_streak == 4'hF) ? 4'hF : state.spike_streak + 4'd1;
   assign bad_inc    = {1'b0, state.bad_count} + 5'd1;
   assign good_sat   = (state.good_streak == 8'hFF) ? 8'hFF : state.good_streak + 8'd1;

   // floor((4*f + s) / 5), done on a biased non-negative dividend.
   assign acc      = $signed({state.filtered_temp[13], state.filtered_temp, 2'b00})
                   + $signed({{3{s14[13]}}, s14});
   assign acc_bias = $unsigned(acc) + DIV5_BIAS;
   assign prod     = {17'd0, acc_bias} * {17'd0, DIV5_RECIP};
   assign quo      = prod[DIV5_SHIFT +: 16];
   assign avg_full = quo - DIV5_UNBIAS;
   assign avg      = $signed(avg_full[13:0]);

   always_comb begin
      nxt    = state;
      status = STATUS_UPDATED;
      reinit = 1'b0;
      update = 1'b0;
      if (bad) begin
         nxt.good_streak = 8'd0;
         status          = STATUS_BAD;
         if (bad_inc >= {1'b0, cfg.bad_read_limit}) begin
            nxt.bad_count = 4'd0;
            reinit        = 1'b1;
         end else begin
            nxt.bad_count = bad_inc[3:0];
         end
      end else begin
         nxt.bad_count = 4'd0;
         update        = 1'b1;
         if (state.have_filtered) begin
            if (spike) begin
               nxt.spike_streak = streak_sat;
               if (streak_sat < cfg.spike_confirm_count) begin
                  update = 1'b0;
                  status = STATUS_SPIKE;
               end
            end else begin
               nxt.spike_streak = 4'd0;
            end
            if (update) begin
               nxt.filtered_temp = avg;
            end
         end else begin
            nxt.filtered_temp = s14;
            nxt.have_filtered = 1'b1;
            nxt.spike_streak  = 4'd0;
         end
         if (update) begin
            nxt.good_streak = good_sat;
            if (good_sat >= cfg.valid_after_count) begin
               nxt.valid_flag = 1'b1;
            end
         end
      end
   end

   assign shown_sum = $signed({nxt.filtered_temp[13], nxt.filtered_temp})
                    + $signed({{4{cfg.correction_offset[10]}}, cfg.correction_offset});

   assign state_next            = nxt;
   assign result.shown_temp     = nxt.have_filtered ? $signed({shown_sum[14], shown_sum})
                                                    : 16'sd0;
   assign result.status         = status;
   assign result.reinit_request = reinit;
   assign result.live           = nxt.have_filtered;
   assign result.local_valid    = nxt.valid_flag;

endmodule

// File: src/temp_spike_reject_ema_filter.sv
`timescale 1ns / 1ps
// A result is offered once its input has passed the input register and then the result
// register. Throughput: one item per cycle, set by the combinational filter update
// between the input register and the result register; a stalled result blocks only once
// the input register is also full. Reset is synchronous and active high: it clears the
// filter state and the valid flags of both pipeline registers and restores every
// configuration register.

module temp_spike_reject_ema_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   tsre_req_if.sink                             req,
   tsre_rsp_if.source                           rsp,
   input  logic                                 csr_we,
   input  logic [tsre_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tsre_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import tsre_pkg::*;

   cfg_type            cfg;
   state_type          state_ff;
   state_type          state_in;
   result_type         step_result;
   result_type         out_ff;
   logic               stg_valid_ff;
   logic               stg_read_ok_ff;
   logic signed [15:0] stg_sample_ff;
   logic               out_valid_ff;
   logic               advance;

   tsre_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tsre_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .read_ok    (stg_read_ok_ff),
      .sample     (stg_sample_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   // The staged item commits its state update when it moves into the result register.
   assign advance   = stg_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !stg_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            stg_valid_ff <= req.valid;
         end
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         stg_read_ok_ff <= req.read_ok;
         stg_sample_ff  <= req.sample;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.shown_temp     = out_ff.shown_temp;
   assign rsp.status         = out_ff.status;
   assign rsp.reinit_request = out_ff.reinit_request;
   assign rsp.live           = out_ff.live;
   assign rsp.local_valid    = out_ff.local_valid;

   a_reinit_only_on_bad: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.reinit_request |-> rsp.status == STATUS_BAD)
      else $error("reinit request on a result that is not a bad read");

   a_zero_until_live: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.live |-> rsp.shown_temp == 16'sd0)
      else $error("nonzero temperature shown before the filter is loaded");

   a_valid_needs_live: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.local_valid |-> rsp.live)
      else $error("valid flag set without a loaded filter");

   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.valid_flag |=> state_ff.valid_flag)
      else $error("sticky valid flag cleared without reset");

   a_live_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.have_filtered |=> state_ff.have_filtered)
      else $error("filter lost its loaded state without reset");

endmodule
